// ----- rtl/kf_pkg.sv -----
// shared types and constants for the constant-velocity kalman filter
`default_nettype none
package kf_pkg;
    localparam int CovW = 32;
    localparam int RegW = 31;
    localparam logic [CovW-1:0] OneQ24 = 32'h0100_0000;
    localparam logic [RegW-1:0] QReset = 31'd1678;
    localparam logic [RegW-1:0] RReset = 31'd16777216;
    localparam logic [0:0] RegQ = 1'b0;
    localparam logic [0:0] RegR = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_PRED, ST_DIV0, ST_DIV1, ST_MX, ST_MV,
        ST_M00, ST_M01, ST_M10, ST_M11, ST_DONE
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/kf_div.sv -----
// restoring divider, one quotient bit per cycle, q = num*2^24 / den truncated
`default_nettype none
module kf_div
    import kf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic signed [CovW-1:0] num,
    input  wire logic [CovW:0]     den,
    output logic                   done,
    output logic signed [CovW-1:0] quot
);
    localparam int NW = 56;
    logic [NW-1:0] n_reg, n_next;
    logic [NW:0] rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, neg_reg, neg_next;
    logic [NW:0] trial;
    logic [NW:0] qabs;

    // one shift-subtract step per cycle
    always_comb begin
        n_next = n_reg; rem_next = rem_reg; q_next = q_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; neg_next = neg_reg;
        trial = {rem_reg[NW-1:0], n_reg[NW-1]};
        if (start) begin
            neg_next = num[CovW-1];
            n_next = {(num[CovW-1] ? NW'(-$signed({{(NW-CovW){num[CovW-1]}}, num}))
                                   : NW'({{(NW-CovW){1'b0}}, num})) } << 24;
            rem_next = '0; q_next = '0; cnt_next = 6'd0; busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = n_reg << 1;
            if (trial >= {{(NW-CovW){1'b0}}, den}) begin
                rem_next = trial - {{(NW-CovW){1'b0}}, den};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NW-1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; cnt_reg <= cnt_next;
        end
        n_reg <= n_next; rem_reg <= rem_next; q_reg <= q_next; neg_reg <= neg_next;
    end

    // sign and saturate
    assign done = busy_reg && (cnt_reg == 6'(NW-1)) ? 1'b0 : (!busy_reg && cnt_reg == 6'(NW));
    always_comb begin
        qabs = {1'b0, q_reg};
        if (neg_reg) quot = (qabs > (NW+1)'(33'h8000_0000)) ? 32'sh8000_0000
                                                           : CovW'(-$signed(qabs));
        else quot = (qabs > (NW+1)'(32'h7fff_ffff)) ? 32'sh7fff_ffff : CovW'(qabs);
    end
endmodule
`default_nettype wire

// ----- rtl/kf_mul.sv -----
// shared q8.24 multiplier: round((k*b)/2^24) with ties up, one registered product
`default_nettype none
module kf_mul
    import kf_pkg::*;
#(
    parameter int DW = 32
) (
    input  wire logic                   aclk,
    input  wire logic signed [CovW-1:0] k,
    input  wire logic signed [DW-1:0]   b,
    output logic signed [DW+8:0]        prod
);
    localparam int PW = CovW + DW;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_round;

    // product register
    always_ff @(posedge aclk) begin
        p_reg <= PW'(k) * PW'(b);
    end

    // round and shift with floor; result fits in DW+9 bits
    assign p_round = p_reg + PW'(64'sd8388608);
    assign prod = (DW+9)'(p_round >>> 24);
endmodule
`default_nettype wire

// ----- rtl/kalman_filter_pos_vel.sv -----
// top level: two-state constant-velocity kalman filter with shared mul and divider
// channel | dir | fields (low bit up)
// s_axis  | in  | measurement[DATA_WIDTH]
// m_axis  | out | position_estimate, velocity_estimate, position_variance[31], pad
// cfg     | in  | cfg_index 0 process_noise, 1 measurement_noise
// a beat runs from acceptance through a predict step, a division per gain on the
// bit-serial divider, 6 multiply issues through the one registered multiplier
// and a last writeback; with a nonpositive innovation variance the divider is
// skipped and both gains are set to zero.
// reset sets state to zero and covariance to identity. s_axis_tready is low
// while a beat is in work or the result waits; it rises the cycle after the result
// beat is taken, so no new beat is accepted before the last result is taken.
`default_nettype none
module kalman_filter_pos_vel
    import kf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DATA_WIDTH-1:0] s_axis_tdata,   // measurement
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [((2*DATA_WIDTH + RegW + 7) / 8) * 8 - 1:0] m_axis_tdata,
                                       // position, velocity, variance, pad
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [RegW-1:0]       cfg_wdata
);
    localparam int OW = ((2*DATA_WIDTH + RegW + 7) / 8) * 8;
    localparam int DW = DATA_WIDTH;
    localparam int BW = (DW > CovW) ? DW : CovW;
    localparam int SW = BW + 11;
    localparam logic signed [DW-1:0] DMax = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMin = {1'b1, {(DW-1){1'b0}}};

    state_t state_reg, state_next;
    logic [RegW-1:0] q_reg, r_reg;
    logic signed [DW-1:0] x_reg, v_reg, xp_reg, z_reg, e_reg;
    logic signed [CovW-1:0] p_reg [4];
    logic signed [CovW-1:0] a_reg [4];
    logic signed [CovW-1:0] k0_reg, k1_reg;
    logic [CovW:0] s_reg;
    logic spos_reg;
    logic out_v_reg;
    logic [OW-1:0] out_reg;

    function automatic logic signed [CovW-1:0] sat32(input logic signed [SW-1:0] v);
        if (v > SW'(33'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (v < -SW'(34'sh8000_0000)) return 32'sh8000_0000;
        return CovW'(v);
    endfunction
    function automatic logic signed [DW-1:0] satd(input logic signed [SW-1:0] v);
        if (v > SW'(DMax)) return DMax;
        if (v < SW'(DMin)) return DMin;
        return v[DW-1:0];
    endfunction

    // predict sums
    logic signed [SW-1:0] a00s, a01s, a10s, a11s, xps, es;
    logic signed [CovW-1:0] a00c;
    logic signed [CovW:0] s_sum;
    always_comb begin
        a00s = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2])
             + SW'(p_reg[3]) + SW'({1'b0, q_reg});
        a01s = SW'(p_reg[1]) + SW'(p_reg[3]);
        a10s = SW'(p_reg[2]) + SW'(p_reg[3]);
        a11s = SW'(p_reg[3]) + SW'({1'b0, q_reg});
        xps = SW'(x_reg) + SW'(v_reg);
        es = SW'(z_reg) - SW'(xp_reg);
        a00c = sat32(a00s);
        s_sum = (CovW+1)'(a00c) + (CovW+1)'({1'b0, r_reg});
    end

    // divider
    logic div_start, div_done;
    logic signed [CovW-1:0] div_num, div_q;
    assign div_num = (state_reg == ST_DIV0) ? a_reg[0] : a_reg[2];
    kf_div u_div (.aclk, .aresetn, .start(div_start), .num(div_num), .den(s_reg),
                  .done(div_done), .quot(div_q));
    logic div_run_reg;

    // multiplier operand select: state issues, next state consumes
    logic signed [CovW-1:0] mk;
    logic signed [BW-1:0] mb;
    logic signed [BW+8:0] mp;
    always_comb begin
        mk = k0_reg; mb = BW'(e_reg);
        case (state_reg)
            ST_MX:  begin mk = k0_reg; mb = BW'(e_reg); end
            ST_MV:  begin mk = k1_reg; mb = BW'(e_reg); end
            ST_M00: begin mk = k0_reg; mb = BW'(a_reg[0]); end
            ST_M01: begin mk = k0_reg; mb = BW'(a_reg[1]); end
            ST_M10: begin mk = k1_reg; mb = BW'(a_reg[0]); end
            ST_M11: begin mk = k1_reg; mb = BW'(a_reg[1]); end
            default: ;
        endcase
    end
    kf_mul #(.DW(BW)) u_mul (.aclk, .k(mk), .b(mb), .prod(mp));

    logic [3:0] wb_reg;    // which result the registered product belongs to
    logic signed [SW-1:0] mpx;
    assign mpx = SW'(mp);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid && !out_v_reg) state_next = ST_PRED;
            ST_PRED: state_next = ST_DIV0;
            ST_DIV0: if (!spos_reg || (div_run_reg && div_done)) state_next = ST_DIV1;
            ST_DIV1: if (!spos_reg || (div_run_reg && div_done)) state_next = ST_MX;
            ST_MX:   state_next = ST_MV;
            ST_MV:   state_next = ST_M00;
            ST_M00:  state_next = ST_M01;
            ST_M01:  state_next = ST_M10;
            ST_M10:  state_next = ST_M11;
            ST_M11:  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        div_start = 1'b0;
        if ((state_reg == ST_DIV0 || state_reg == ST_DIV1) && !div_run_reg && spos_reg)
            div_start = 1'b1;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    logic signed [CovW-1:0] p00n;
    assign p00n = sat32(SW'(a_reg[0]) - mpx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            q_reg <= QReset; r_reg <= RReset;
            x_reg <= '0; v_reg <= '0;
            p_reg[0] <= OneQ24; p_reg[1] <= '0; p_reg[2] <= '0; p_reg[3] <= OneQ24;
            out_v_reg <= 1'b0; div_run_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index == RegQ) q_reg <= cfg_wdata;
                else r_reg <= cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) out_v_reg <= 1'b0;
            // divider handshake; nonpositive s gives zero gains
            if (state_reg == ST_DIV0 || state_reg == ST_DIV1) begin
                if (!spos_reg) begin
                    if (state_reg == ST_DIV0) k0_reg <= '0; else k1_reg <= '0;
                    div_run_reg <= 1'b0;
                end else if (div_start) div_run_reg <= 1'b1;
                else if (div_done) begin
                    div_run_reg <= 1'b0;
                    if (state_reg == ST_DIV0) k0_reg <= div_q; else k1_reg <= div_q;
                end
            end
            // writebacks from the multiplier, in the cycle after issue
            case (wb_reg)
                4'd1: x_reg <= satd(SW'(xp_reg) + mpx);
                4'd2: v_reg <= satd(SW'(v_reg) + mpx);
                4'd3: p_reg[0] <= p00n;
                4'd4: p_reg[1] <= sat32(SW'(a_reg[1]) - mpx);
                4'd5: p_reg[2] <= sat32(SW'(a_reg[2]) - mpx);
                4'd6: p_reg[3] <= sat32(SW'(a_reg[3]) - mpx);
                default: ;
            endcase
            if (wb_reg == 4'd3) begin
                out_reg[OW-1:2*DW] <= {{(OW-2*DW-RegW){1'b0}},
                    p00n[CovW-1] ? {RegW{1'b0}} : p00n[RegW-1:0]};
            end
            if (wb_reg == 4'd6) begin
                out_reg[2*DW-1:0] <= {v_reg, x_reg};
                out_v_reg <= 1'b1;
            end
        end
        // payload
        if (s_axis_tready && s_axis_tvalid) z_reg <= s_axis_tdata;
        if (state_reg == ST_PRED) begin
            a_reg[0] <= a00c; a_reg[1] <= sat32(a01s);
            a_reg[2] <= sat32(a10s); a_reg[3] <= sat32(a11s);
            xp_reg <= satd(xps);
            s_reg <= s_sum;
            spos_reg <= !s_sum[CovW] && (s_sum != '0);
        end
        if (state_reg == ST_DIV0) e_reg <= satd(es);
        case (state_reg)
            ST_MX: wb_reg <= 4'd1;
            ST_MV: wb_reg <= 4'd2;
            ST_M00: wb_reg <= 4'd3;
            ST_M01: wb_reg <= 4'd4;
            ST_M10: wb_reg <= 4'd5;
            ST_M11: wb_reg <= 4'd6;
            default: wb_reg <= 4'd0;
        endcase
    end
endmodule
`default_nettype wire
